// File: rtl/tsp_pkg.sv
// Shared types and constants of the triangle sweep servo PWM unit.
// No dependencies; every other file imports this package.
package tsp_pkg;

    localparam int MAX_SERVOS = 12;
    localparam int SERVO_IW   = $clog2(MAX_SERVOS);
    localparam int PWM_W      = 12;
    localparam int POS_W      = 8;
    localparam int STEP_W     = 8;
    localparam int INTV_W     = 16;
    localparam int CNT_W      = 4;
    localparam int ELAP_W     = 17;
    localparam int CFG_IW     = 2;
    localparam int CFG_DW     = 16;
    localparam int FULL_SWEEP = 180;

    localparam logic [ELAP_W-1:0] ELAPSED_MAX = '1;

    // register indexes of the configuration port
    localparam logic [CFG_IW-1:0] CFG_SWEEP_STEP      = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_UPDATE_INTERVAL = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SERVO_COUNT     = 2'd2;

    // divide by 180: multiply by floor(2^28/180), then one correction step
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = 20;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((2 ** RECIP_SHIFT) / FULL_SWEEP);

    // result queue
    localparam int RES_DEPTH = 8;
    localparam int RES_PW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_LOAD  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                en;
        logic [SERVO_IW-1:0] idx;
        logic [PWM_W-1:0]    lo;
        logic [PWM_W-1:0]    hi;
    } t_lim_wr;

    typedef struct packed {
        logic [SERVO_IW-1:0] channel;
        logic [PWM_W-1:0]    pwm_count;
        logic [POS_W-1:0]    position;
        logic                last;
    } t_result;

endpackage

// File: rtl/tsp_job_fifo.sv
// Two-entry queue of sweep positions between the front and back parts.
// Depends on tsp_pkg.
module tsp_job_fifo
    import tsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [POS_W-1:0] i_pos,
    input  logic             i_pop,
    output logic [POS_W-1:0] o_pos,
    output logic             o_empty,
    output logic             o_full
);

    logic [POS_W-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_pos   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pos;
        end
    end

endmodule

// File: rtl/tsp_res_fifo.sv
// Result queue that drives the output side of the unit.
// Depends on tsp_pkg.
module tsp_res_fifo
    import tsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_data,
    input  logic              i_pop,
    output t_result           o_data,
    output logic              o_empty,
    output logic [RES_CW-1:0] o_count
);

    t_result           r_mem [RES_DEPTH];
    logic [RES_PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [RES_PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [RES_CW-1:0] r_count, n_count;
    logic              pop_ok;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + RES_PW'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = r_rd_ptr + RES_PW'(1);
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + RES_CW'(1);
        end else if (!i_push && pop_ok) begin
            n_count = r_count - RES_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/tsp_front.sv
// Front part: configuration registers, command decode and sweep state.
// Emits one job (new position) per sweep update. Depends on tsp_pkg.
module tsp_front
    import tsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                i_push,
    input  logic [1:0]          i_mode,
    input  logic [SERVO_IW-1:0] i_servo_index,
    input  logic [PWM_W-1:0]    i_limit_min,
    input  logic [PWM_W-1:0]    i_limit_max,
    input  logic                i_job_full,
    input  logic                i_quiet,
    output logic                o_full,
    output logic                o_job_push,
    output logic [POS_W-1:0]    o_job_pos,
    output t_lim_wr             o_lim_wr,
    output logic [CNT_W-1:0]    o_servo_count
);

    localparam int POS_SW = POS_W + 2;
    localparam logic signed [POS_SW-1:0] SWEEP_LIM = POS_SW'(FULL_SWEEP);

    logic [STEP_W-1:0] r_sweep_step;
    logic [INTV_W-1:0] r_update_interval;
    logic [CNT_W-1:0]  r_servo_count;

    logic              r_running, n_running;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_down, n_down;
    logic [ELAP_W-1:0] r_elapsed, n_elapsed;

    t_mode                    mode;
    logic                     accept;
    logic [ELAP_W-1:0]        elap_inc;
    logic signed [POS_SW-1:0] pos_next;

    assign mode          = t_mode'(i_mode);
    assign o_servo_count = r_servo_count;

    // loads wait until the back part has read everything queued before them
    always_comb begin
        case (mode)
            MODE_TICK: o_full = i_job_full;
            MODE_LOAD: o_full = !i_quiet;
            default:   o_full = 1'b0;
        endcase
    end

    assign accept = i_push && !o_full;

    always_comb begin
        elap_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + ELAP_W'(1) : r_elapsed;
        if (r_down) begin
            pos_next = $signed({2'b00, r_pos}) - $signed({2'b00, r_sweep_step});
        end else begin
            pos_next = $signed({2'b00, r_pos}) + $signed({2'b00, r_sweep_step});
        end
    end

    always_comb begin
        n_running     = r_running;
        n_pos         = r_pos;
        n_down        = r_down;
        n_elapsed     = r_elapsed;
        o_job_push    = 1'b0;
        o_lim_wr.en   = 1'b0;
        o_lim_wr.idx  = i_servo_index;
        o_lim_wr.lo   = i_limit_min;
        o_lim_wr.hi   = i_limit_max;
        if (accept) begin
            case (mode)
                MODE_START: begin
                    n_running = 1'b1;
                    n_pos     = '0;
                    n_down    = 1'b0;
                    n_elapsed = '0;
                end
                MODE_STOP: begin
                    n_running = 1'b0;
                end
                MODE_LOAD: begin
                    o_lim_wr.en = ({1'b0, i_servo_index} < (SERVO_IW + 1)'(MAX_SERVOS));
                end
                MODE_TICK: begin
                    if (r_running) begin
                        if (elap_inc > {1'b0, r_update_interval}) begin
                            n_elapsed  = '0;
                            o_job_push = 1'b1;
                            if (pos_next >= SWEEP_LIM) begin
                                n_pos  = POS_W'(FULL_SWEEP);
                                n_down = 1'b1;
                            end else if (pos_next <= 0) begin
                                n_pos  = '0;
                                n_down = 1'b0;
                            end else begin
                                n_pos = pos_next[POS_W-1:0];
                            end
                        end else begin
                            n_elapsed = elap_inc;
                        end
                    end
                end
                default: begin
                    n_running = r_running;
                end
            endcase
        end
    end

    assign o_job_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_pos     <= '0;
            r_down    <= 1'b0;
            r_elapsed <= '0;
        end else begin
            r_running <= n_running;
            r_pos     <= n_pos;
            r_down    <= n_down;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_step      <= STEP_W'(1);
            r_update_interval <= INTV_W'(20);
            r_servo_count     <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SWEEP_STEP:      r_sweep_step      <= i_cfg_data[STEP_W-1:0];
                CFG_UPDATE_INTERVAL: r_update_interval <= i_cfg_data[INTV_W-1:0];
                CFG_SERVO_COUNT:     r_servo_count     <= i_cfg_data[CNT_W-1:0];
                default:             r_servo_count     <= r_servo_count;
            endcase
        end
    end

endmodule

// File: rtl/tsp_back.sv
// Back part: limit tables and the per-channel mapping pipeline
// (operand fetch, multiply, reciprocal divide, correct). Depends on tsp_pkg.
module tsp_back
    import tsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  logic [POS_W-1:0]  i_job_pos,
    input  logic [CNT_W-1:0]  i_servo_count,
    input  t_lim_wr           i_lim_wr,
    input  logic [RES_CW-1:0] i_res_count,
    output logic              o_job_pop,
    output logic              o_idle,
    output logic              o_res_push,
    output t_result           o_res
);

    logic [PWM_W-1:0] r_min_tab [MAX_SERVOS];
    logic [PWM_W-1:0] r_max_tab [MAX_SERVOS];

    logic                r_busy, n_busy;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SERVO_IW-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]    r_n, n_n;

    // pipeline stages
    logic                r1_valid, r2_valid, r3_valid;
    logic [SERVO_IW-1:0] r1_chan, r2_chan, r3_chan;
    logic                r1_last, r2_last, r3_last;
    logic [POS_W-1:0]    r1_pos, r2_pos, r3_pos;
    logic [PWM_W-1:0]    r1_lo, r2_lo, r3_lo;
    logic                r1_neg, r2_neg, r3_neg;
    logic [PWM_W-1:0]    r1_mag;
    logic [PROD_W-1:0]   r2_prod, r3_prod;
    logic [PWM_W-1:0]    r3_qest;

    logic [CNT_W-1:0]          n_sat;
    logic [1:0]                inflight;
    logic [RES_CW:0]           pending;
    logic                      credit;
    logic                      issue;
    logic                      last_ch;
    logic [PWM_W-1:0]          tab_lo, tab_hi;
    logic [PROD_W+RECIP_W-1:0] q_full;
    logic [PROD_W-1:0]         q_back, rem;
    logic [PWM_W-1:0]          q_fix;

    assign n_sat = (i_servo_count > CNT_W'(MAX_SERVOS)) ? CNT_W'(MAX_SERVOS) : i_servo_count;

    assign inflight = {1'b0, r1_valid} + {1'b0, r2_valid} + {1'b0, r3_valid};
    assign pending  = {1'b0, i_res_count} + {{(RES_CW - 1){1'b0}}, inflight};
    assign credit   = (pending < (RES_CW + 1)'(RES_DEPTH));

    assign issue     = r_busy && credit;
    assign last_ch   = (CNT_W'(r_idx) + CNT_W'(1) == r_n);
    assign o_job_pop = !r_busy && !i_job_empty;
    assign o_idle    = !r_busy;

    assign tab_lo = r_min_tab[r_idx];
    assign tab_hi = r_max_tab[r_idx];

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        n_idx  = r_idx;
        n_n    = r_n;
        if (o_job_pop) begin
            n_pos  = i_job_pos;
            n_n    = n_sat;
            n_idx  = '0;
            n_busy = (n_sat != '0);
        end else if (issue) begin
            if (last_ch) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + SERVO_IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_n      <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_n      <= n_n;
            r1_valid <= issue;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_lim_wr.en) begin
            r_min_tab[i_lim_wr.idx] <= i_lim_wr.lo;
            r_max_tab[i_lim_wr.idx] <= i_lim_wr.hi;
        end
    end

    assign q_full = r2_prod * RECIP_K;

    always_ff @(posedge i_clk) begin
        // operand fetch: split the span into sign and magnitude
        r1_chan <= r_idx;
        r1_last <= last_ch;
        r1_pos  <= r_pos;
        r1_lo   <= tab_lo;
        r1_neg  <= (tab_lo > tab_hi);
        r1_mag  <= (tab_lo > tab_hi) ? tab_lo - tab_hi : tab_hi - tab_lo;
        // multiply
        r2_chan <= r1_chan;
        r2_last <= r1_last;
        r2_pos  <= r1_pos;
        r2_lo   <= r1_lo;
        r2_neg  <= r1_neg;
        r2_prod <= {{(PROD_W - POS_W){1'b0}}, r1_pos} * {{(PROD_W - PWM_W){1'b0}}, r1_mag};
        // quotient estimate, at most one below the true quotient
        r3_chan <= r2_chan;
        r3_last <= r2_last;
        r3_pos  <= r2_pos;
        r3_lo   <= r2_lo;
        r3_neg  <= r2_neg;
        r3_prod <= r2_prod;
        r3_qest <= q_full[RECIP_SHIFT +: PWM_W];
    end

    always_comb begin
        q_back = {{(PROD_W - PWM_W){1'b0}}, r3_qest} * PROD_W'(FULL_SWEEP);
        rem    = r3_prod - q_back;
        q_fix  = r3_qest + {{(PWM_W - 1){1'b0}}, (rem >= PROD_W'(FULL_SWEEP))};
    end

    // magnitude quotient with the span's sign gives truncation toward zero
    assign o_res_push      = r3_valid;
    assign o_res.channel   = r3_chan;
    assign o_res.pwm_count = r3_neg ? r3_lo - q_fix : r3_lo + q_fix;
    assign o_res.position  = r3_pos;
    assign o_res.last      = r3_last;

endmodule

// File: rtl/triangle_sweep_servo_pwm_unit.sv
// Triangle sweep servo PWM unit: top level with front, job queue, back and result queue.
// An updating tick yields n results (n = servo count, at most 12), one per cycle while
// the result queue has room; the first passes the job queue, the back part's operand
// fetch, multiply and quotient estimate registers and the result queue before it shows.
// The back part's shared mapping pipeline takes one channel a cycle while room lasts.
// Reset (synchronous, active low) clears state and queues; limit tables stay unwritten.
module triangle_sweep_servo_pwm_unit
    import tsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_mode,
    input  logic [SERVO_IW-1:0] i_servo_index,
    input  logic [PWM_W-1:0]    i_limit_min,
    input  logic [PWM_W-1:0]    i_limit_max,
    output logic                empty,
    input  logic                pop,
    output logic [SERVO_IW-1:0] o_channel,
    output logic [PWM_W-1:0]    o_pwm_count,
    output logic [POS_W-1:0]    o_position,
    output logic                o_last
);

    logic              job_push, job_pop, job_empty, job_full;
    logic [POS_W-1:0]  job_pos_in, job_pos_out;
    logic              back_idle, quiet;
    logic [CNT_W-1:0]  servo_count;
    t_lim_wr           lim_wr;
    logic              res_push;
    t_result           res_in, res_out;
    logic [RES_CW-1:0] res_count;

    assign o_cfg_ready = 1'b1;
    assign quiet       = job_empty && back_idle;

    tsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_mode        (i_mode),
        .i_servo_index (i_servo_index),
        .i_limit_min   (i_limit_min),
        .i_limit_max   (i_limit_max),
        .i_job_full    (job_full),
        .i_quiet       (quiet),
        .o_full        (full),
        .o_job_push    (job_push),
        .o_job_pos     (job_pos_in),
        .o_lim_wr      (lim_wr),
        .o_servo_count (servo_count)
    );

    tsp_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_pos   (job_pos_in),
        .i_pop   (job_pop),
        .o_pos   (job_pos_out),
        .o_empty (job_empty),
        .o_full  (job_full)
    );

    tsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (job_empty),
        .i_job_pos     (job_pos_out),
        .i_servo_count (servo_count),
        .i_lim_wr      (lim_wr),
        .i_res_count   (res_count),
        .o_job_pop     (job_pop),
        .o_idle        (back_idle),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    tsp_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_channel   = res_out.channel;
    assign o_pwm_count = res_out.pwm_count;
    assign o_position  = res_out.position;
    assign o_last      = res_out.last;

endmodule

// File: tb/tsp_pwm_checker.sv
// Checker for the triangle sweep servo PWM unit: tracks sweep state, limit tables and
// registers from observed transfers, predicts each PWM result and compares in order.
// Depends on tsp_pkg for widths, register indexes, modes and the result struct.
`timescale 1ns / 100ps
module tsp_pwm_checker
    import tsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                i_push,
    input  logic                i_full,
    input  logic [1:0]          i_mode,
    input  logic [SERVO_IW-1:0] i_servo_index,
    input  logic [PWM_W-1:0]    i_limit_min,
    input  logic [PWM_W-1:0]    i_limit_max,
    input  logic                i_empty,
    input  logic                i_pop,
    input  logic [SERVO_IW-1:0] i_channel,
    input  logic [PWM_W-1:0]    i_pwm_count,
    input  logic [POS_W-1:0]    i_position,
    input  logic                i_last,
    output int                  o_pending,
    output int                  o_fail_count
);

    logic [STEP_W-1:0] step_cfg;
    logic [INTV_W-1:0] interval_cfg;
    logic [CNT_W-1:0]  count_cfg;
    logic              running;
    logic [POS_W-1:0]  sweep_pos;
    logic              going_down;
    logic [ELAP_W-1:0] elapsed;
    logic [PWM_W-1:0]  min_lim [MAX_SERVOS];
    logic [PWM_W-1:0]  max_lim [MAX_SERVOS];
    t_result           pwm_expected [$];
    int                waiting = 0;
    int                fails = 0;

    assign o_pending    = waiting;
    assign o_fail_count = fails;

    // linear map of 0..180 onto [lo, hi], quotient truncated toward zero
    function automatic logic [PWM_W-1:0] pwm_for(logic [POS_W-1:0] pos,
                                                 logic [PWM_W-1:0] lo,
                                                 logic [PWM_W-1:0] hi);
        int span;
        int scaled;
        span   = int'(hi) - int'(lo);
        scaled = (int'(pos) * span) / FULL_SWEEP + int'(lo);
        return scaled[PWM_W-1:0];
    endfunction

    function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        int p;
        int n;
        t_result want;
        if (!i_rst_n) begin
            step_cfg     = STEP_W'(1);
            interval_cfg = INTV_W'(20);
            count_cfg    = CNT_W'(1);
            running      = 1'b0;
            sweep_pos    = '0;
            going_down   = 1'b0;
            elapsed      = '0;
            pwm_expected.delete();
        end else begin
            // results always come after their tick, so compare first
            if (i_pop && !i_empty) begin
                if (pwm_expected.size() == 0) begin
                    fails++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got ch %0d pwm %0d pos %0d last %0b"},
                             $time, i_channel, i_pwm_count, i_position, i_last);
                end else begin
                    want = pwm_expected.pop_front();
                    fails += field_diff("channel", want.channel, i_channel);
                    fails += field_diff("pwm_count", want.pwm_count, i_pwm_count);
                    fails += field_diff("position", want.position, i_position);
                    fails += field_diff("last", want.last, i_last);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SWEEP_STEP:      step_cfg     = i_cfg_data[STEP_W-1:0];
                    CFG_UPDATE_INTERVAL: interval_cfg = i_cfg_data[INTV_W-1:0];
                    CFG_SERVO_COUNT:     count_cfg    = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (i_push && !i_full) begin
                case (i_mode)
                    MODE_START: begin
                        running    = 1'b1;
                        sweep_pos  = '0;
                        going_down = 1'b0;
                        elapsed    = '0;
                    end
                    MODE_STOP: begin
                        running = 1'b0;
                    end
                    MODE_LOAD: begin
                        if (i_servo_index < MAX_SERVOS) begin
                            min_lim[i_servo_index] = i_limit_min;
                            max_lim[i_servo_index] = i_limit_max;
                        end
                    end
                    default: begin
                        if (running) begin
                            if (elapsed != ELAPSED_MAX)
                                elapsed = elapsed + 1'b1;
                            if (elapsed > interval_cfg) begin
                                p = going_down ? int'(sweep_pos) - int'(step_cfg)
                                               : int'(sweep_pos) + int'(step_cfg);
                                // clamp at either end and turn around
                                if (p >= FULL_SWEEP) begin
                                    p          = FULL_SWEEP;
                                    going_down = 1'b1;
                                end else if (p <= 0) begin
                                    p          = 0;
                                    going_down = 1'b0;
                                end
                                sweep_pos = POS_W'(p);
                                elapsed   = '0;
                                n = (count_cfg > MAX_SERVOS) ? MAX_SERVOS : int'(count_cfg);
                                for (int i = 0; i < n; i++) begin
                                    want.channel   = SERVO_IW'(i);
                                    want.pwm_count = pwm_for(sweep_pos, min_lim[i], max_lim[i]);
                                    want.position  = sweep_pos;
                                    want.last      = (i + 1 == n);
                                    pwm_expected.push_back(want);
                                end
                            end
                        end
                    end
                endcase
            end
        end
        waiting = pwm_expected.size();
    end

endmodule

// File: tb/triangle_sweep_servo_pwm_unit_tb.sv
// Top of the testbench for the triangle sweep servo PWM unit: clock, reset, register
// writes and item stimulus with random idling on both sides, plus the final verdict.
// Depends on tsp_pkg, the unit itself and tsp_pwm_checker.
`timescale 1ns / 100ps
module triangle_sweep_servo_pwm_unit_tb;
    import tsp_pkg::*;

    localparam int HOLD_CYCLES   = 100;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 245;
    localparam int PHASE_ITEMS   = 35;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [1:0]          i_mode = '0;
    logic [SERVO_IW-1:0] i_servo_index = '0;
    logic [PWM_W-1:0]    i_limit_min = '0;
    logic [PWM_W-1:0]    i_limit_max = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [SERVO_IW-1:0] o_channel;
    logic [PWM_W-1:0]    o_pwm_count;
    logic [POS_W-1:0]    o_position;
    logic                o_last;

    int pending;
    int fail_count;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_on = 1'b0;
    bit hold_served = 1'b0;
    int counted = 0;

    always #1 i_clk = ~i_clk;

    triangle_sweep_servo_pwm_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_servo_index (i_servo_index),
        .i_limit_min   (i_limit_min),
        .i_limit_max   (i_limit_max),
        .empty         (empty),
        .pop           (pop),
        .o_channel     (o_channel),
        .o_pwm_count   (o_pwm_count),
        .o_position    (o_position),
        .o_last        (o_last)
    );

    tsp_pwm_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_mode        (i_mode),
        .i_servo_index (i_servo_index),
        .i_limit_min   (i_limit_min),
        .i_limit_max   (i_limit_max),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_channel     (o_channel),
        .i_pwm_count   (o_pwm_count),
        .i_position    (o_position),
        .i_last        (o_last),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // push stays high after a transfer; a gap or a drain lowers it
    task automatic send_item(t_mode m, logic [SERVO_IW-1:0] idx,
                             logic [PWM_W-1:0] lo, logic [PWM_W-1:0] hi);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_mode        <= m;
        i_servo_index <= idx;
        i_limit_min   <= lo;
        i_limit_max   <= hi;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        counted++;
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // loads and quiet ticks may still be in flight behind the last result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [STEP_W-1:0] step, logic [INTV_W-1:0] intv,
                            logic [CNT_W-1:0] cnt);
        drain_results();
        write_reg(CFG_SWEEP_STEP, CFG_DW'(step));
        write_reg(CFG_UPDATE_INTERVAL, intv);
        write_reg(CFG_SERVO_COUNT, CFG_DW'(cnt));
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !hold_served) begin
                pop     <= 1'b0;
                hold_on  = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on     = 1'b0;
                hold_served = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int pick;
        int phase;
        int target;
        t_mode m;
        logic [STEP_W-1:0] step;
        logic [INTV_W-1:0] intv;
        logic [CNT_W-1:0] cnt;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-sweep step: consecutive updates hit 180 then 0; count above the table saturates
        set_regs(8'd180, 16'd0, 4'd15);
        send_item(MODE_TICK, 4'hF, 12'hFFF, 12'hFFF);   // stopped, ignored
        send_item(MODE_LOAD, 4'd0, 12'd0, 12'd4095);
        send_item(MODE_LOAD, 4'd1, 12'd4095, 12'd0);
        send_item(MODE_LOAD, 4'd2, 12'd4095, 12'd4095);
        send_item(MODE_LOAD, 4'd3, 12'd0, 12'd0);
        send_item(MODE_LOAD, 4'd4, 12'hAAA, 12'h555);   // min above max
        for (int s = 5; s < MAX_SERVOS; s++)
            send_item(MODE_LOAD, SERVO_IW'(s), PWM_W'($urandom), PWM_W'($urandom));
        send_item(MODE_LOAD, 4'd12, 12'h123, 12'h456);  // out of range, dropped
        send_item(MODE_LOAD, 4'd15, 12'hFFF, 12'h000);
        send_item(MODE_START, 4'd0, 12'd0, 12'd0);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);
        send_item(MODE_STOP, 4'd0, 12'd0, 12'd0);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);
        send_item(MODE_START, 4'd0, 12'd0, 12'd0);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);

        // zero step while clamped at 180; zero count updates silently
        set_regs(8'd0, 16'd1, 4'd0);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);
        set_regs(8'd0, 16'd0, 4'd2);
        send_item(MODE_TICK, 4'd0, 12'd0, 12'd0);

        // result side held off while full updates pile up
        set_regs(STEP_W'($urandom_range(1, 180)), 16'd0, 4'd12);
        hold_req = 1'b1;
        wait (hold_on);
        send_item(MODE_START, 4'd0, 12'd0, 12'd0);
        repeat (12)
            send_item(MODE_TICK, SERVO_IW'($urandom), PWM_W'($urandom), PWM_W'($urandom));

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       step = 8'd0;
                1:       step = 8'd1;
                2:       step = 8'd180;
                3:       step = 8'd255;
                default: step = STEP_W'($urandom_range(2, 179));
            endcase
            case (phase % 8)
                1, 6:    intv = 16'd1;
                2:       intv = 16'd2;
                3:       intv = 16'd65535;
                5:       intv = 16'd3;
                default: intv = 16'd0;
            endcase
            cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 15))
                                              : CNT_W'($urandom_range(1, 12));
            set_regs(step, intv, cnt);
            calm   = (counted >= RANDOM_ITEMS - PHASE_ITEMS);
            target = counted + PHASE_ITEMS;
            while (counted < target && counted < RANDOM_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    m = MODE_TICK;
                else if (pick < 92)
                    m = MODE_LOAD;
                else if (pick < 97)
                    m = MODE_START;
                else
                    m = MODE_STOP;
                send_item(m, SERVO_IW'($urandom_range(0, 15)), PWM_W'($urandom),
                          PWM_W'($urandom));
            end
            phase++;
        end

        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: triangle_sweep_servo_pwm_unit.f
rtl/tsp_pkg.sv
rtl/tsp_job_fifo.sv
rtl/tsp_res_fifo.sv
rtl/tsp_front.sv
rtl/tsp_back.sv
rtl/triangle_sweep_servo_pwm_unit.sv
tb/tsp_pwm_checker.sv
tb/triangle_sweep_servo_pwm_unit_tb.sv
